// ===== rtl/pse_pkg.sv =====
package pse_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_STEPS   = 48;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE, S_POP_R, S_POP_L, S_EXEC, S_MULFIN, S_POWMUL, S_POWACC,
        S_DIV, S_DIVFIN, S_PUSH, S_END
    } state_t;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW
    } op_t;

    typedef struct packed {
        logic        fault;
        logic [31:0] value;
    } sat_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t s;
        if (v > 64'sd2147483647)
        begin
            s.fault = 1'b1;
            s.value = Q_MAX;
        end
        else if (v < -64'sd2147483648)
        begin
            s.fault = 1'b1;
            s.value = Q_MIN;
        end
        else
        begin
            s.fault = 1'b0;
            s.value = v[31:0];
        end
        return s;
    endfunction

    // integer part, truncated toward zero
    function automatic logic [15:0] trunc_int(input logic [31:0] q);
        logic [15:0] n;
        n = q[31:16];
        if (q[31] && (q[15:0] != 16'h0))
            n = n + 16'd1;
        return n;
    endfunction

endpackage

// ===== rtl/pse_if.sv =====
interface pse_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface pse_res_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] answer;
    logic        underflow_seen;
    logic        overflow_seen;
    logic        arith_fault;

    modport source (output valid, output answer, output underflow_seen,
                    output overflow_seen, output arith_fault, input ready);
    modport sink   (input valid, input answer, input underflow_seen,
                    input overflow_seen, input arith_fault, output ready);
endinterface

// ===== rtl/postfix_stack_evaluator.sv =====
// A digit is pushed at once; an operator pops two operands and pushes one result;
// / and % skip the divider on a zero divisor, $ multiplies once per unit of the
// integer exponent and divides 1.0 by that for a negative one. One item at a time:
// the stack RAM port, the shared multiplier and the one-bit-a-cycle divider serve it.
// A result waits in an output register while the next item is taken.
// Reset clears the stack count, the flags and the sequencer; RAM is not cleared.
module postfix_stack_evaluator (
    input  logic      clk,
    input  logic      rst_n,
    pse_sym_if.sink   sym,
    pse_res_if.source res
);

    pse_pkg::state_t state_reg, state_next;
    pse_pkg::op_t    op_reg, op_next;

    logic [pse_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       uflow_reg, uflow_next;
    logic                       oflow_reg, oflow_next;
    logic                       fault_reg, fault_next;
    logic                       hit_reg, hit_next;
    logic signed [31:0]         left_reg, left_next;
    logic signed [31:0]         right_reg, right_next;
    logic signed [31:0]         acc_reg, acc_next;
    logic [31:0]                result_reg, result_next;
    logic signed [63:0]         prod_reg, prod_next;
    logic [15:0]                reps_reg, reps_next;
    logic                       pneg_reg, pneg_next;
    logic                       neg_reg, neg_next;
    logic [31:0]                rem_reg, rem_next;
    logic [47:0]                quo_reg, quo_next;
    logic [31:0]                dvs_reg, dvs_next;
    logic [pse_pkg::STEP_W-1:0] step_reg, step_next;
    logic                       ovalid_reg, ovalid_next;
    logic [31:0]                ans_reg, ans_next;
    logic                       ouf_reg, ouf_next;
    logic                       oof_reg, oof_next;
    logic                       oaf_reg, oaf_next;

    logic                       we, re;
    logic [pse_pkg::ADDR_W-1:0] waddr, raddr;
    logic [31:0]                wdata, rdata;
    logic                       is_digit, is_op, out_free;
    pse_pkg::op_t               dec_op;
    logic signed [31:0]         mul_b;
    logic signed [63:0]         product;
    logic [15:0]                ib_int;

    pse_ram #(.WIDTH(32), .DEPTH(pse_pkg::STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sym.ready          = (state_reg == pse_pkg::S_IDLE);
    assign res.valid          = ovalid_reg;
    assign res.answer         = ans_reg;
    assign res.underflow_seen = ouf_reg;
    assign res.overflow_seen  = oof_reg;
    assign res.arith_fault    = oaf_reg;
    assign out_free           = !ovalid_reg || res.ready;

    assign is_digit = (sym.symbol >= pse_pkg::CH_ZERO) && (sym.symbol <= pse_pkg::CH_NINE);
    assign mul_b    = (state_reg == pse_pkg::S_POWMUL) ? acc_reg : right_reg;
    assign product  = 64'(left_reg) * 64'(mul_b);
    assign ib_int   = pse_pkg::trunc_int(right_reg);

    always_comb
    begin
        is_op  = 1'b1;
        dec_op = pse_pkg::OP_ADD;
        unique case (sym.symbol)
            pse_pkg::CH_PLUS:   dec_op = pse_pkg::OP_ADD;
            pse_pkg::CH_MINUS:  dec_op = pse_pkg::OP_SUB;
            pse_pkg::CH_STAR:   dec_op = pse_pkg::OP_MUL;
            pse_pkg::CH_SLASH:  dec_op = pse_pkg::OP_DIV;
            pse_pkg::CH_PCT:    dec_op = pse_pkg::OP_MOD;
            pse_pkg::CH_DOLLAR: dec_op = pse_pkg::OP_POW;
            default:            is_op  = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pse_pkg::S_IDLE:
                if (sym.valid)
                begin
                    if (sym.symbol == pse_pkg::CH_NUL)
                        state_next = pse_pkg::S_END;
                    else if (is_op)
                        state_next = pse_pkg::S_POP_R;
                end
            pse_pkg::S_POP_R: state_next = pse_pkg::S_POP_L;
            pse_pkg::S_POP_L: state_next = pse_pkg::S_EXEC;
            pse_pkg::S_EXEC:
                unique case (op_reg)
                    pse_pkg::OP_MUL: state_next = pse_pkg::S_MULFIN;
                    pse_pkg::OP_DIV:
                        state_next = (right_reg == 32'sd0) ? pse_pkg::S_PUSH
                                                           : pse_pkg::S_DIV;
                    pse_pkg::OP_MOD:
                        state_next = (ib_int == 16'h0) ? pse_pkg::S_PUSH : pse_pkg::S_DIV;
                    pse_pkg::OP_POW:
                        state_next = (pse_pkg::trunc_int(right_reg) == 16'h0)
                                     ? pse_pkg::S_PUSH : pse_pkg::S_POWMUL;
                    default: state_next = pse_pkg::S_PUSH;
                endcase
            pse_pkg::S_MULFIN: state_next = pse_pkg::S_PUSH;
            pse_pkg::S_POWMUL: state_next = pse_pkg::S_POWACC;
            pse_pkg::S_POWACC:
                if (reps_reg != 16'h0)
                    state_next = pse_pkg::S_POWMUL;
                else
                    state_next = pneg_reg ? pse_pkg::S_EXEC : pse_pkg::S_PUSH;
            pse_pkg::S_DIV:
                if (step_reg == pse_pkg::STEP_W'(1))
                    state_next = pse_pkg::S_DIVFIN;
            pse_pkg::S_DIVFIN: state_next = pse_pkg::S_PUSH;
            pse_pkg::S_PUSH:   state_next = pse_pkg::S_IDLE;
            pse_pkg::S_END:
                if (out_free)
                    state_next = pse_pkg::S_IDLE;
            default: state_next = pse_pkg::S_IDLE;
        endcase
    end

    // datapath and stack access
    always_comb
    begin
        pse_pkg::sat_t      s;
        logic [15:0]        n, ia, mag16, rm;
        logic [31:0]        abs_a, abs_b;
        logic [32:0]        sh;
        logic [31:0]        q32;

        op_next     = op_reg;
        count_next  = count_reg;
        uflow_next  = uflow_reg;
        oflow_next  = oflow_reg;
        fault_next  = fault_reg;
        hit_next    = hit_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        prod_next   = prod_reg;
        reps_next   = reps_reg;
        pneg_next   = pneg_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        step_next   = step_reg;
        ovalid_next = ovalid_reg && !res.ready;
        ans_next    = ans_reg;
        ouf_next    = ouf_reg;
        oof_next    = oof_reg;
        oaf_next    = oaf_reg;
        we          = 1'b0;
        re          = 1'b0;
        waddr       = count_reg[pse_pkg::ADDR_W-1:0];
        wdata       = result_reg;
        raddr       = pse_pkg::ADDR_W'(count_reg - pse_pkg::CNT_W'(1));
        s           = '0;
        n           = '0;
        ia          = '0;
        mag16       = '0;
        rm          = '0;
        abs_a       = '0;
        abs_b       = '0;
        sh          = '0;
        q32         = '0;

        unique case (state_reg)
            pse_pkg::S_IDLE:
                if (sym.valid)
                begin
                    if (is_digit)
                    begin
                        wdata = {12'h0, 4'(sym.symbol - pse_pkg::CH_ZERO), 16'h0};
                        if (count_reg == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
                            oflow_next = 1'b1;
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + pse_pkg::CNT_W'(1);
                        end
                    end
                    else if (is_op || (sym.symbol == pse_pkg::CH_NUL))
                    begin
                        op_next = dec_op;
                        if (count_reg == '0)
                        begin
                            hit_next   = 1'b0;
                            uflow_next = 1'b1;
                        end
                        else
                        begin
                            hit_next   = 1'b1;
                            re         = 1'b1;
                            count_next = count_reg - pse_pkg::CNT_W'(1);
                        end
                    end
                end
            pse_pkg::S_POP_R:
            begin
                right_next = hit_reg ? rdata : pse_pkg::Q_NEG_ONE;
                if (count_reg == '0)
                begin
                    hit_next   = 1'b0;
                    uflow_next = 1'b1;
                end
                else
                begin
                    hit_next   = 1'b1;
                    re         = 1'b1;
                    count_next = count_reg - pse_pkg::CNT_W'(1);
                end
            end
            pse_pkg::S_POP_L:
                left_next = hit_reg ? rdata : pse_pkg::Q_NEG_ONE;
            pse_pkg::S_EXEC:
            begin
                abs_a = left_reg[31] ? (~left_reg + 32'd1) : left_reg;
                abs_b = right_reg[31] ? (~right_reg + 32'd1) : right_reg;
                unique case (op_reg)
                    pse_pkg::OP_ADD:
                    begin
                        s           = pse_pkg::sat32(64'(left_reg) + 64'(right_reg));
                        result_next = s.value;
                        fault_next  = fault_reg | s.fault;
                    end
                    pse_pkg::OP_SUB:
                    begin
                        s           = pse_pkg::sat32(64'(left_reg) - 64'(right_reg));
                        result_next = s.value;
                        fault_next  = fault_reg | s.fault;
                    end
                    pse_pkg::OP_MUL:
                        prod_next = product;
                    pse_pkg::OP_DIV:
                        if (right_reg == 32'sd0)
                        begin
                            fault_next = 1'b1;
                            if (left_reg > 32'sd0)
                                result_next = pse_pkg::Q_MAX;
                            else if (left_reg < 32'sd0)
                                result_next = pse_pkg::Q_MIN;
                            else
                                result_next = '0;
                        end
                        else
                        begin
                            neg_next  = left_reg[31] ^ right_reg[31];
                            rem_next  = '0;
                            quo_next  = {abs_a, 16'h0};
                            dvs_next  = abs_b;
                            step_next = pse_pkg::STEP_W'(pse_pkg::DIV_STEPS);
                        end
                    pse_pkg::OP_MOD:
                    begin
                        ia = pse_pkg::trunc_int(left_reg);
                        if (ib_int == 16'h0)
                        begin
                            fault_next  = 1'b1;
                            result_next = '0;
                        end
                        else
                        begin
                            neg_next  = ia[15];
                            rem_next  = '0;
                            quo_next  = {32'h0, ia[15] ? (~ia + 16'd1) : ia};
                            dvs_next  = {16'h0, ib_int[15] ? (~ib_int + 16'd1) : ib_int};
                            step_next = pse_pkg::STEP_W'(pse_pkg::DIV_STEPS);
                        end
                    end
                    pse_pkg::OP_POW:
                    begin
                        n           = pse_pkg::trunc_int(right_reg);
                        reps_next   = n[15] ? (~n + 16'd1) : n;
                        pneg_next   = n[15];
                        acc_next    = pse_pkg::Q_ONE;
                        result_next = pse_pkg::Q_ONE;
                    end
                    default: ;
                endcase
            end
            pse_pkg::S_MULFIN:
            begin
                s           = pse_pkg::sat32(prod_reg >>> 16);
                result_next = s.value;
                fault_next  = fault_reg | s.fault;
            end
            pse_pkg::S_POWMUL:
            begin
                prod_next = product;
                reps_next = reps_reg - 16'd1;
            end
            pse_pkg::S_POWACC:
            begin
                s           = pse_pkg::sat32(prod_reg >>> 16);
                acc_next    = s.value;
                result_next = s.value;
                fault_next  = fault_reg | s.fault;
                // negative exponent: rerun as 1.0 / acc
                if ((reps_reg == 16'h0) && pneg_reg)
                begin
                    left_next  = pse_pkg::Q_ONE;
                    right_next = s.value;
                    op_next    = pse_pkg::OP_DIV;
                    pneg_next  = 1'b0;
                end
            end
            pse_pkg::S_DIV:
            begin
                sh = {rem_reg, quo_reg[47]};
                if (sh >= {1'b0, dvs_reg})
                begin
                    rem_next = 32'(sh - {1'b0, dvs_reg});
                    quo_next = {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[31:0];
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                step_next = step_reg - pse_pkg::STEP_W'(1);
            end
            pse_pkg::S_DIVFIN:
                if (op_reg == pse_pkg::OP_MOD)
                begin
                    mag16       = rem_reg[15:0];
                    rm          = neg_reg ? (~mag16 + 16'd1) : mag16;
                    result_next = {rm, 16'h0};
                end
                else
                begin
                    q32 = quo_reg[31:0];
                    if (!neg_reg && (quo_reg > 48'h0000_7FFF_FFFF))
                    begin
                        fault_next  = 1'b1;
                        result_next = pse_pkg::Q_MAX;
                    end
                    else if (neg_reg && (quo_reg > 48'h0000_8000_0000))
                    begin
                        fault_next  = 1'b1;
                        result_next = pse_pkg::Q_MIN;
                    end
                    else
                        result_next = neg_reg ? (~q32 + 32'd1) : q32;
                end
            pse_pkg::S_PUSH:
                if (count_reg == pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
                    oflow_next = 1'b1;
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + pse_pkg::CNT_W'(1);
                end
            pse_pkg::S_END:
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ans_next    = hit_reg ? rdata : pse_pkg::Q_NEG_ONE;
                    ouf_next    = uflow_reg;
                    oof_next    = oflow_reg;
                    oaf_next    = fault_reg;
                    count_next  = '0;
                    uflow_next  = 1'b0;
                    oflow_next  = 1'b0;
                    fault_next  = 1'b0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pse_pkg::S_IDLE;
            count_reg  <= '0;
            uflow_reg  <= 1'b0;
            oflow_reg  <= 1'b0;
            fault_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            step_reg   <= '0;
            reps_reg   <= '0;
            pneg_reg   <= 1'b0;
            op_reg     <= pse_pkg::OP_ADD;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            uflow_reg  <= uflow_next;
            oflow_reg  <= oflow_next;
            fault_reg  <= fault_next;
            ovalid_reg <= ovalid_next;
            hit_reg    <= hit_next;
            step_reg   <= step_next;
            reps_reg   <= reps_next;
            pneg_reg   <= pneg_next;
            op_reg     <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        ans_reg    <= ans_next;
        ouf_reg    <= ouf_next;
        oof_reg    <= oof_next;
        oaf_reg    <= oaf_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH))
        else $error("stack count beyond depth");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (count_reg < pse_pkg::CNT_W'(pse_pkg::STACK_DEPTH)))
        else $error("stack write while full");

    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pse_pkg::S_DIV) |-> (step_reg != '0))
        else $error("divider ran past its last step");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        (!ovalid_reg ##1 ovalid_reg) |-> $past(state_reg == pse_pkg::S_END))
        else $error("result raised outside end of expression");

endmodule

// ===== rtl/pse_ram.sv =====
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule
